[src/sliding_window_rate_estimator_defines.svh]
// Assertion macros for the rate estimator checker.
`ifndef SLIDING_WINDOW_RATE_ESTIMATOR_DEFINES_SVH
`define SLIDING_WINDOW_RATE_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWRE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swre: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SWRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swre: next-cycle check failed");

`endif

[src/swre_pkg.sv]
// ---------------------------------------------------------------------------
// swre_pkg
// Types, widths, codes and helpers for the sliding-window rate estimator.
// ---------------------------------------------------------------------------
package swre_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

   localparam int SAMPLE_W   = 32;
   localparam int RATE_W     = 32;
   localparam int LEN_W      = 7;
   localparam int PERIOD_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   // datapath widths
   localparam int NN_W  = 3 * CNT_W;                      // n*(n*n-1)
   localparam int MA_W  = SAMPLE_W + 1;                   // multiplier port a
   localparam int MB_W  = NN_W + 1;                       // multiplier port b
   localparam int P_W   = MA_W + MB_W;
   localparam int ACC_W = SAMPLE_W + CNT_W + 1 + IDX_W;   // weighted sum
   localparam int NUM_W = ACC_W + 11;                     // sum * 1536
   localparam int DEN_W = NN_W + PERIOD_W;
   localparam int DIT_W = $clog2(NUM_W + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_MODE    = 2'd2;

   localparam logic FUNC_SAMPLE   = 1'b0;
   localparam logic FUNC_CLEAR    = 1'b1;
   localparam logic MODE_ENDPOINT = 1'b0;
   localparam logic MODE_LSQ      = 1'b1;

   localparam logic [LEN_W-1:0]    WINDOW_LENGTH_RST = 7'd1;
   localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 16'd256;

   localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
   localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

   typedef struct packed {
      logic                       func;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate;
      logic                     ready_res;
   } rsp_type;

   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
   } div_cmd_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [RATE_W-1:0] rate;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_SRD,
      ST_SMUL,
      ST_SACC,
      ST_DN1,
      ST_DN2,
      ST_DN3,
      ST_DN4,
      ST_LOAD,
      ST_DIV,
      ST_RESP
   } state_type;

   // Ring buffer address of logical entry ofs, oldest at base.
   function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
      if (s >= (CNT_W+1)'(MAX_WINDOW)) begin
         s = s - (CNT_W+1)'(MAX_WINDOW);
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

[src/swre_mul.sv]
// ---------------------------------------------------------------------------
// swre_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
module swre_mul
   import swre_pkg::*;
(
   input  logic                  clock,
   input  logic signed [MA_W-1:0] mul_a,
   input  logic signed [MB_W-1:0] mul_b,
   output logic signed [P_W-1:0]  prod_ff
);

   logic signed [P_W-1:0] prod_in;

   assign prod_in = P_W'(mul_a) * P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[src/swre_div.sv]
// ---------------------------------------------------------------------------
// swre_div
// Restoring signed divider, one quotient bit per cycle, truncates toward
// zero and saturates the quotient to the rate range.
// ---------------------------------------------------------------------------
module swre_div
   import swre_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_cmd_type  cmd,
   output div_stat_type stat
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     neg_ff, neg_in;
   logic [NUM_W-1:0]         quo_ff, quo_in;
   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [DIT_W-1:0]         cnt_ff, cnt_in;
   logic signed [RATE_W-1:0] rate_ff, rate_in;

   logic [DEN_W:0]  trial;
   logic            pos_ovf;
   logic            neg_ovf;

   assign trial   = {rem_ff, quo_ff[NUM_W-1]};
   assign pos_ovf = |quo_ff[NUM_W-1:RATE_W-1];
   assign neg_ovf = (|quo_ff[NUM_W-1:RATE_W]) ||
                    (quo_ff[RATE_W-1] && (|quo_ff[RATE_W-2:0]));

   // next values
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      rate_in = rate_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         neg_in  = cmd.num[NUM_W-1];
         quo_in  = cmd.num[NUM_W-1] ? NUM_W'(-cmd.num) : NUM_W'(cmd.num);
         rem_in  = '0;
         den_in  = cmd.den;
         cnt_in  = DIT_W'(NUM_W);
      end else if (busy_ff && (cnt_ff != '0)) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIT_W'(1);
      end else if (busy_ff) begin
         // quotient magnitude complete: sign and saturate
         busy_in = 1'b0;
         done_in = 1'b1;
         if (!neg_ff && pos_ovf) begin
            rate_in = RATE_MAX;
         end else if (neg_ff && neg_ovf) begin
            rate_in = RATE_MIN;
         end else if (neg_ff) begin
            rate_in = -$signed(quo_ff[RATE_W-1:0]);
         end else begin
            rate_in = $signed(quo_ff[RATE_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      rate_ff <= rate_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.rate = rate_ff;

endmodule

[src/sliding_window_rate_estimator.sv]
// ---------------------------------------------------------------------------
// sliding_window_rate_estimator
// Rate of change of a Q16.16 channel over a window of recent samples.
// ---------------------------------------------------------------------------
// One transaction at a time: req_ready is high only when the block is idle,
// and each transaction gives one response. A clear goes straight to the response.
// Endpoint mode (slope_mode 0) makes two window reads, one multiply for the
// denominator, and a 57-step restoring divide, then signs, saturates and
// reports. Regression mode has one shared multiplier walk the ring buffer
// memory, read, multiply, accumulate, per sample, then build the denominator
// in three multiplies, then the same divider runs; with fewer than two
// samples it answers a zero rate. Response stalls hold the result in the
// response state. The window memory needs no clearing pass; a fill count
// tracks which entries are live.
// ---------------------------------------------------------------------------
module sliding_window_rate_estimator
   import swre_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [LEN_W-1:0]    wl_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic                mode_ff;

   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic signed [RATE_W-1:0] rate_ff, rate_in;
   logic                     rres_ff, rres_in;

   logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic [IDX_W-1:0]           raddr;
   logic [IDX_W-1:0]           waddr;
   logic                       mem_we;

   logic                   req_fire;
   logic [CNT_W-1:0]       len_eff;
   logic [PERIOD_W-1:0]    period_eff;
   logic [CNT_W-1:0]       fill_upd;
   logic [IDX_W-1:0]       head_upd;
   logic [CMP_W-1:0]       wl_ext;
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [P_W-1:0]  prod;
   logic signed [MB_W-1:0] weight;
   logic signed [NUM_W-1:0] num_ext;
   logic signed [NUM_W-1:0] num;
   div_cmd_type            div_cmd;
   div_stat_type           div_stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff     <= WINDOW_LENGTH_RST;
         period_ff <= SAMPLE_PERIOD_RST;
         mode_ff   <= MODE_ENDPOINT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: wl_ff     <= csr_wdata[LEN_W-1:0];
            CSR_SAMPLE_PERIOD: period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_SLOPE_MODE:    mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective window length and period
   assign wl_ext = CMP_W'(wl_ff);
   always_comb begin
      if (wl_ext == '0) begin
         len_eff = CNT_W'(1);
      end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
         len_eff = CNT_W'(MAX_WINDOW);
      end else begin
         len_eff = CNT_W'(wl_ext);
      end
   end
   assign period_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

   // window update: grow, or drop the oldest and write past the newest
   assign req_fire = req_valid && req_ready;
   assign fill_upd = (fill_ff < len_eff) ? fill_ff + CNT_W'(1) : fill_ff;
   assign head_upd = (fill_ff < len_eff) ? head_ff : phys_addr(head_ff, CNT_W'(1));
   assign waddr    = phys_addr(head_ff, fill_ff);
   assign mem_we   = req_fire && (req_data.func == FUNC_SAMPLE);

   // window memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= req_data.sample;
      end
      rd_ff <= mem[raddr];
   end

   assign weight  = $signed(MB_W'({idx_ff, 1'b0}) - MB_W'(fill_ff) + MB_W'(1));
   assign num_ext = NUM_W'(acc_ff);
   assign num     = (mode_ff == MODE_LSQ) ? (num_ext <<< 10) + (num_ext <<< 9)
                                          : (num_ext <<< 8);

   swre_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   swre_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.func == FUNC_CLEAR) begin
                  state_in = ST_RESP;
               end else if (mode_ff == MODE_ENDPOINT) begin
                  state_in = ST_RD0;
               end else if (fill_upd < CNT_W'(2)) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SRD;
               end
            end
         end
         ST_RD0:  state_in = ST_RD1;
         ST_RD1:  state_in = ST_RD2;
         ST_RD2:  state_in = ST_LOAD;
         ST_SRD:  state_in = ST_SMUL;
         ST_SMUL: state_in = ST_SACC;
         ST_SACC: state_in = (idx_ff == fill_ff - CNT_W'(1)) ? ST_DN1 : ST_SRD;
         ST_DN1:  state_in = ST_DN2;
         ST_DN2:  state_in = ST_DN3;
         ST_DN3:  state_in = ST_DN4;
         ST_DN4:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV:  state_in = div_stat.done ? ST_RESP : ST_DIV;
         ST_RESP: state_in = rsp_ready ? ST_IDLE : ST_RESP;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake, read address, multiplier operands, divide start
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      raddr         = phys_addr(head_ff, idx_ff);
      mul_a         = '0;
      mul_b         = '0;
      div_cmd.start = 1'b0;
      div_cmd.num   = num;
      div_cmd.den   = den_ff;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_RD0:  raddr = phys_addr(head_ff, '0);
         ST_RD1: begin
            raddr = phys_addr(head_ff, fill_ff - CNT_W'(1));
            mul_a = MA_W'($signed({1'b0, period_eff}));
            mul_b = MB_W'($signed({1'b0, fill_ff}));
         end
         ST_SMUL: begin
            mul_a = MA_W'(rd_ff);
            mul_b = weight;
         end
         ST_DN1: begin
            mul_a = MA_W'($signed({1'b0, fill_ff}));
            mul_b = MB_W'($signed({1'b0, fill_ff}));
         end
         ST_DN2: begin
            mul_a = MA_W'($signed({1'b0, fill_ff}));
            mul_b = MB_W'(prod) - MB_W'(1);
         end
         ST_DN3: begin
            mul_a = MA_W'($signed({1'b0, period_eff}));
            mul_b = MB_W'(prod);
         end
         ST_LOAD: div_cmd.start = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      fill_in = fill_ff;
      head_in = head_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      den_in  = den_ff;
      rate_in = rate_ff;
      rres_in = rres_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rate_in = '0;
               idx_in  = '0;
               acc_in  = '0;
               if (req_data.func == FUNC_CLEAR) begin
                  fill_in = '0;
                  head_in = '0;
                  rres_in = 1'b0;
               end else begin
                  fill_in = fill_upd;
                  head_in = head_upd;
                  rres_in = (fill_upd >= len_eff);
               end
            end
         end
         ST_RD2: begin
            // oldest sample sits in acc, newest just read
            acc_in = ACC_W'(rd_ff) - acc_ff;
            den_in = prod[DEN_W-1:0];
         end
         ST_SACC: begin
            acc_in = acc_ff + ACC_W'(prod);
            idx_in = idx_ff + CNT_W'(1);
         end
         ST_DN4:  den_in = prod[DEN_W-1:0];
         ST_DIV: begin
            if (div_stat.done) begin
               rate_in = div_stat.rate;
            end
         end
         default: ;
      endcase
      if (state_ff == ST_RD1) begin
         acc_in = ACC_W'(rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         head_ff  <= '0;
         rres_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         head_ff  <= head_in;
         rres_ff  <= rres_in;
      end
      idx_ff  <= idx_in;
      acc_ff  <= acc_in;
      den_ff  <= den_in;
      rate_ff <= rate_in;
   end

   assign rsp_data.rate      = rate_ff;
   assign rsp_data.ready_res = rres_ff;

endmodule

[src/swre_checker.sv]
// ---------------------------------------------------------------------------
// swre_checker
// Port-level checks of the rate estimator's transaction sequencing.
// ---------------------------------------------------------------------------
`include "sliding_window_rate_estimator_defines.svh"

module swre_checker
   import swre_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_data
);

   // a stalled response holds its payload
   `SWRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // an accepted request makes the block busy
   `SWRE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // no new request while a response is pending
   `SWRE_ASSERT_NOW(a_one_in_flight, clock, reset, rsp_valid, !req_ready)

   // a response is not repeated after it is accepted
   `SWRE_ASSERT_NEXT(a_single_rsp, clock, reset, rsp_valid && rsp_ready, !rsp_valid)

endmodule

bind sliding_window_rate_estimator swre_checker u_swre_checker (.*);

[sim/sliding_window_rate_estimator_tb.sv]
// ---------------------------------------------------------------------------
// sliding_window_rate_estimator_tb
// Self-checking bench for the sliding-window rate estimator. It drives sample
// and clear transactions with random gaps and response stalls, and tracks the
// window in a local predictor. Every response is checked field by field.
// Endpoint and regression modes, window lengths and sample periods are swept
// between phases.
// ---------------------------------------------------------------------------
module sliding_window_rate_estimator_tb;
   import swre_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Window predictor and queue of expected responses
   class rate_scoreboard;
      logic [LEN_W-1:0]    win_len;
      logic [PERIOD_W-1:0] period;
      logic                mode;
      longint              window [MAX_WINDOW];
      int                  fill;
      rsp_type             pending [$];
      int                  errors;

      function void clear_state();
         int i;
         for (i = 0; i < MAX_WINDOW; i++) window[i] = 0;
         fill = 0;
         win_len = WINDOW_LENGTH_RST;
         period = SAMPLE_PERIOD_RST;
         mode = MODE_ENDPOINT;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_WINDOW_LENGTH: win_len = val[LEN_W-1:0];
            CSR_SAMPLE_PERIOD: period = val;
            CSR_SLOPE_MODE:    mode = val[0];
            default: ;
         endcase
      endfunction

      function longint saturate(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Note an accepted request and queue its expected response
      function void note_request(req_type r);
         int len, i;
         longint per, s, den, rate;
         rsp_type e;
         len = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len));
         per = (period == 0) ? 1 : longint'(period);
         if (r.func == FUNC_CLEAR) begin
            for (i = 0; i < MAX_WINDOW; i++) window[i] = 0;
            fill = 0;
            e.rate = '0;
            e.ready_res = 1'b0;
            pending.push_back(e);
            return;
         end
         if (fill < len) begin
            window[fill] = longint'(r.sample);
            fill++;
         end else begin
            for (i = 0; i < fill - 1; i++) window[i] = window[i+1];
            window[fill-1] = longint'(r.sample);
         end
         if (mode == MODE_ENDPOINT) begin
            rate = saturate(((window[fill-1] - window[0]) * 256) / (longint'(fill) * per));
         end else if (fill < 2) begin
            rate = 0;
         end else begin
            s = 0;
            for (i = 0; i < fill; i++) s += (2 * i - fill + 1) * window[i];
            den = longint'(fill) * (longint'(fill) * fill - 1) * per;
            rate = saturate((s * 6 * 256) / den);
         end
         e.rate = rate[31:0];
         e.ready_res = (fill >= len);
         pending.push_back(e);
      endfunction

      // Compare one response with the oldest expectation
      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response rate=%0d ready_res=%0b",
                     $realtime, a.rate, a.ready_res);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.rate !== e.rate) begin
            $display("%0t: rate expected %0d actual %0d", $realtime, e.rate, a.rate);
            errors++;
         end
         if (a.ready_res !== e.ready_res) begin
            $display("%0t: ready_res expected %0b actual %0b",
                     $realtime, e.ready_res, a.ready_res);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rate_scoreboard sb;
   int  cycles;
   bit  stall_off;     // no response stalls in the last part
   bit  long_hold;     // long response hold-off request
   bit  sb_ready;

   sliding_window_rate_estimator uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      sb = new();
      sb.clear_state();
      sb_ready = 1'b1;
   end

   // Timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Track accepted transactions on both channels
   always @(posedge clock) begin
      if (!reset && sb_ready) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // Response side: random stall bursts, plus one long hold-off
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (3000) @(negedge clock);
            long_hold = 1'b0;
         end else if (!stall_off && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   task automatic send_item(logic func, logic [31:0] value, bit gaps);
      req_type r;
      if (gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      r.func = func;
      r.sample = value;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   task automatic set_phase(int len, int per, int mode);
      write_csr(CSR_WINDOW_LENGTH, len[CSR_DATA_W-1:0]);
      write_csr(CSR_SAMPLE_PERIOD, per[CSR_DATA_W-1:0]);
      write_csr(CSR_SLOPE_MODE, mode[CSR_DATA_W-1:0]);
   endtask

   // Main stimulus
   initial begin
      int p, k, cnt, len;
      stall_off = 1'b0;
      long_hold = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_WINDOW_LENGTH;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset config, extremes, clear, zero length/period
      send_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b0);
      send_item(FUNC_SAMPLE, 32'h8000_0000, 1'b0);
      drain();
      set_phase(4, 1, int'(MODE_ENDPOINT));
      send_item(FUNC_SAMPLE, 32'h8000_0000, 1'b0);
      send_item(FUNC_SAMPLE, 32'h0000_0000, 1'b0);
      send_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b0);
      send_item(FUNC_SAMPLE, 32'hFFFF_FFFF, 1'b0);
      send_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b0);
      drain();
      write_csr(CSR_SLOPE_MODE, CSR_DATA_W'(MODE_LSQ));
      send_item(FUNC_SAMPLE, 32'h8000_0000, 1'b0);
      send_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b0);
      send_item(FUNC_CLEAR, 32'hFFFF_FFFF, 1'b0);
      send_item(FUNC_SAMPLE, 32'h1234_5678, 1'b0);
      drain();
      // zero length and zero period, both taken as one
      set_phase(0, 0, int'(MODE_LSQ));
      send_item(FUNC_SAMPLE, 32'h0001_0000, 1'b0);
      send_item(FUNC_SAMPLE, 32'h0003_0000, 1'b0);
      drain();
      set_phase(127, 65535, int'(MODE_ENDPOINT));
      send_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b0);
      send_item(FUNC_CLEAR, 32'h0, 1'b0);
      drain();

      // Random phases; long hold-off in one, full drain pause after each
      for (p = 0; p < 24; p++) begin
         case (p % 6)
            0: len = 1;
            1: len = 64;
            2: len = $urandom_range(2, 8);
            3: len = $urandom_range(0, 127);
            default: len = $urandom_range(1, 16);
         endcase
         k = (p % 5 == 0) ? 1 : ((p % 5 == 1) ? 65535 : $urandom_range(0, 65535));
         set_phase(len, k, p % 2);
         if (p == 3) long_hold = 1'b1;
         if (p >= 20) stall_off = 1'b1;
         cnt = (len > 40) ? 90 : 60;
         for (k = 0; k < cnt; k++) begin
            if ($urandom_range(0, 29) == 0)
               send_item(FUNC_CLEAR, $urandom, p < 20);
            else
               send_item(FUNC_SAMPLE, rand_sample(), p < 20);
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
